FILE: rtl/core/thbp_pkg.sv
// Shared types, character constants and the break decision function for the Thai hint block.
package thbp_pkg;

   // TIS-620 character codes used by the decision rules.
   localparam logic [7:0] CH_CONS_KO    = 8'hA1;
   localparam logic [7:0] CH_RU         = 8'hC4;
   localparam logic [7:0] CH_LU         = 8'hC6;
   localparam logic [7:0] CH_CONS_WO    = 8'hC7;
   localparam logic [7:0] CH_CONS_O     = 8'hCD;
   localparam logic [7:0] CH_VOWEL_A    = 8'hD0;
   localparam logic [7:0] CH_HAN_MARK   = 8'hD1;
   localparam logic [7:0] CH_VOWEL_AA   = 8'hD2;
   localparam logic [7:0] CH_VOWEL_UEE  = 8'hD7;
   localparam logic [7:0] CH_LEAD_E     = 8'hE0;
   localparam logic [7:0] CH_LEAD_AE    = 8'hE1;
   localparam logic [7:0] CH_SHORT_MARK = 8'hE7;
   localparam logic [7:0] CH_SILENCER   = 8'hEC;

   // Lookahead window depth and default depth of the queue between front and back.
   localparam int WIN_DEPTH           = 5;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   typedef logic [WIN_DEPTH-1:0][7:0] window_type;

   // One input transaction as held in the queue.
   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } item_type;

   // Head of the queue as seen by the back end.
   typedef struct packed {
      logic     valid;
      item_type item;
   } qhead_type;

   // Outcome of deciding the oldest pending byte.
   typedef struct packed {
      logic       hint;
      logic [2:0] adv;
   } decide_type;

   function automatic logic is_cons(logic [7:0] c);
      return (c inside {[8'hA1:8'hCE]}) && (c != CH_RU) && (c != CH_LU);
   endfunction

   function automatic logic is_tone(logic [7:0] c);
      return c inside {[8'hE8:8'hEB]};
   endfunction

   function automatic logic is_upvowel(logic [7:0] c);
      return (c == CH_HAN_MARK) || (c inside {[8'hD4:8'hD7]});
   endfunction

   function automatic logic is_ldvowel(logic [7:0] c);
      return c inside {[8'hE0:8'hE4]};
   endfunction

   function automatic logic is_han_or_uee(logic [7:0] c);
      return (c == CH_HAN_MARK) || (c == CH_VOWEL_UEE);
   endfunction

   // Decide the oldest byte of the window; n is the number of known bytes (1 to 5).
   function automatic decide_type decide(window_type w, logic [2:0] n, logic [7:0] h0,
                                         logic [7:0] h1, logic [1:0] seen);
      decide_type r;
      logic [7:0] c;
      r.hint = 1'b0;
      r.adv  = 3'd1;
      c      = w[0];
      if (is_cons(c)) begin
         if (n > 3'd1 && w[1] == CH_SILENCER) begin
            r.adv = 3'd2;
         end else if (n > 3'd2 && w[2] == CH_SILENCER) begin
            r.adv = 3'd3;
         end else if (n > 3'd2 && c != CH_CONS_KO && w[1] == CH_SHORT_MARK &&
                      (w[2] == CH_CONS_O || w[2] == CH_CONS_WO)) begin
            r.hint = 1'b1;
            r.adv  = 3'd4;
         end else if ((seen >= 2'd1 && is_han_or_uee(h0)) ||
                      (seen >= 2'd2 && is_tone(h0) && is_han_or_uee(h1))) begin
            r.adv = 3'd1;
         end else begin
            r.hint = 1'b1;
         end
      end else if (c == CH_LEAD_E || c == CH_LEAD_AE) begin
         r.hint = 1'b1;
         if (n <= 3'd2) begin
            r.adv = 3'd2;
         end else if (w[2] == CH_SHORT_MARK) begin
            r.adv = 3'd4;
         end else if (is_upvowel(w[2])) begin
            r.adv = (n > 3'd3 && is_tone(w[3])) ? 3'd5 : 3'd4;
         end else if (n > 3'd4 &&
                      ((w[3] == CH_VOWEL_AA && w[4] == CH_VOWEL_A) ||
                       (w[2] != CH_CONS_KO && w[3] == CH_SHORT_MARK &&
                        w[4] != CH_CONS_O && w[4] != CH_CONS_WO))) begin
            r.adv = 3'd5;
         end else begin
            r.adv = 3'd2;
         end
      end else if (is_ldvowel(c)) begin
         r.hint = 1'b1;
         r.adv  = 3'd2;
      end else if (c == CH_RU || c == CH_LU) begin
         r.hint = 1'b1;
      end
      return r;
   endfunction

endpackage

FILE: rtl/core/thbp_queue.sv
// Front end: accepts input transactions into a short queue ahead of the back end.
module thbp_queue
   import thbp_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   output logic      req_ready,
   input  item_type  req_item,
   output qhead_type head,
   input  logic      pop
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   item_type           mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               push;
   logic               do_pop;

   // Handshake on both sides of the queue.
   assign req_ready  = (count_ff != CNT_W'(DEPTH));
   assign push       = req_valid && req_ready;
   assign head.valid = (count_ff != '0);
   assign head.item  = mem_ff[rd_ptr_ff];
   assign do_pop     = pop && head.valid;

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= req_item;
      end
   end

   // The back end never pops an empty queue.
   assert property (@(posedge clock) disable iff (reset) pop |-> head.valid)
      else $error("pop from empty queue");

   // Occupancy never exceeds the depth.
   assert property (@(posedge clock) disable iff (reset) count_ff <= CNT_W'(DEPTH))
      else $error("queue count overflow");

   // A push into a non-full queue without a pop raises the count by one.
   assert property (@(posedge clock) disable iff (reset)
                    (push && !do_pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count did not follow a push");

endmodule

FILE: rtl/core/thbp_back.sv
// Back end: lookahead window, skip counter, break decision and result register.
module thbp_back
   import thbp_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  qhead_type head,
   output logic      pop,
   output logic      rsp_valid,
   input  logic      rsp_ready,
   output logic      rsp_hint,
   output logic      rsp_out_last
);

   window_type  win_ff, win_in;
   logic [2:0]  fill_ff, fill_in;
   logic [7:0]  hist0_ff, hist0_in;
   logic [7:0]  hist1_ff, hist1_in;
   logic [1:0]  seen_ff, seen_in;
   logic [2:0]  skip_ff, skip_in;
   logic        flushing_ff, flushing_in;
   logic        valid_ff, valid_in;
   logic        hint_ff, hint_in;
   logic        olast_ff, olast_in;

   window_type  step_w;
   logic [2:0]  step_n;
   logic        step_last;
   logic        out_free;
   logic        need_emit;
   logic        emit;
   decide_type  dec;

   assign out_free = !valid_ff || rsp_ready;

   // Window seen by this step: either the pending window during a flush, or with the head byte appended.
   always_comb begin
      step_w = win_ff;
      if (flushing_ff) begin
         step_n    = fill_ff;
         step_last = 1'b1;
      end else begin
         for (int i = 0; i < WIN_DEPTH; i++) begin
            if (fill_ff == 3'(i)) begin
               step_w[i] = head.item.ch;
            end
         end
         step_n    = fill_ff + 3'd1;
         step_last = head.item.last;
      end
   end

   // Step control: a result is produced once the window is full or at the end of a string.
   always_comb begin
      need_emit = (step_n == 3'(WIN_DEPTH)) || step_last;
      if (flushing_ff) begin
         emit = out_free;
         pop  = 1'b0;
      end else begin
         emit = head.valid && need_emit && out_free;
         pop  = head.valid && (!need_emit || out_free);
      end
   end

   assign dec = decide(step_w, step_n, hist0_ff, hist1_ff, seen_ff);

   // Next state of the window, history, skip counter and result register.
   always_comb begin
      win_in      = win_ff;
      fill_in     = fill_ff;
      hist0_in    = hist0_ff;
      hist1_in    = hist1_ff;
      seen_in     = seen_ff;
      skip_in     = skip_ff;
      flushing_in = flushing_ff;
      valid_in    = valid_ff && !rsp_ready;
      hint_in     = hint_ff;
      olast_in    = olast_ff;
      if (emit) begin
         valid_in = 1'b1;
         olast_in = step_last && (step_n == 3'd1);
         if (skip_ff != 3'd0) begin
            hint_in = 1'b0;
            skip_in = skip_ff - 3'd1;
         end else begin
            hint_in = dec.hint;
            skip_in = dec.adv - 3'd1;
         end
         hist1_in = hist0_ff;
         hist0_in = step_w[0];
         if (seen_ff != 2'd2) begin
            seen_in = seen_ff + 2'd1;
         end
         for (int i = 0; i < WIN_DEPTH - 1; i++) begin
            win_in[i] = step_w[i+1];
         end
         win_in[WIN_DEPTH-1] = 8'h00;
         fill_in     = step_n - 3'd1;
         flushing_in = step_last && (step_n != 3'd1);
         // End of string: return to the start-of-string state.
         if (step_last && step_n == 3'd1) begin
            win_in   = '0;
            fill_in  = 3'd0;
            hist0_in = 8'h00;
            hist1_in = 8'h00;
            seen_in  = 2'd0;
            skip_in  = 3'd0;
         end
      end else if (pop) begin
         win_in  = step_w;
         fill_in = step_n;
      end
   end

   // Control and window registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff      <= '0;
         fill_ff     <= 3'd0;
         hist0_ff    <= 8'h00;
         hist1_ff    <= 8'h00;
         seen_ff     <= 2'd0;
         skip_ff     <= 3'd0;
         flushing_ff <= 1'b0;
         valid_ff    <= 1'b0;
      end else begin
         win_ff      <= win_in;
         fill_ff     <= fill_in;
         hist0_ff    <= hist0_in;
         hist1_ff    <= hist1_in;
         seen_ff     <= seen_in;
         skip_ff     <= skip_in;
         flushing_ff <= flushing_in;
         valid_ff    <= valid_in;
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      hint_ff  <= hint_in;
      olast_ff <= olast_in;
   end

   assign rsp_valid    = valid_ff;
   assign rsp_hint     = hint_ff;
   assign rsp_out_last = olast_ff;

   // At rest the window holds at most four bytes; a full window is always decided at once.
   assert property (@(posedge clock) disable iff (reset) fill_ff < 3'(WIN_DEPTH))
      else $error("window fill out of range");

   // A flush is only in progress while bytes remain pending.
   assert property (@(posedge clock) disable iff (reset) flushing_ff |-> (fill_ff != 3'd0))
      else $error("flush with empty window");

   // The skip counter never covers more than four positions.
   assert property (@(posedge clock) disable iff (reset) skip_ff <= 3'd4)
      else $error("skip counter out of range");

   // A produced result is presented on the next cycle.
   assert property (@(posedge clock) disable iff (reset) emit |=> valid_ff)
      else $error("result lost");

endmodule

FILE: rtl/core/thai_break_position_hints_top.sv
// A byte's hint is decided as the fourth following byte is taken and is presented in the
// cycle after; tail hints follow the final byte one per cycle while the receiver is ready
// (up to five results). Throughput: one byte per cycle while the queue has room; one
// decision unit in the back end gives at most one hint per cycle, so after a string's
// final byte it takes none while it flushes, and the queue absorbs input until it fills.
// Reset is synchronous and active high; it empties the queue, clears the window, history,
// skip counter and result valid flag, and the next byte starts a new string.
module thai_break_position_hints_top
   import thbp_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_ch,
   input  logic       req_last,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_hint,
   output logic       rsp_out_last
);

   item_type  req_item;
   qhead_type head;
   logic      pop;

   assign req_item.ch   = req_ch;
   assign req_item.last = req_last;

   // Front end: transaction intake queue.
   thbp_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .head      (head),
      .pop       (pop)
   );

   // Back end: window, decision and result register.
   thbp_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (head),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_hint     (rsp_hint),
      .rsp_out_last (rsp_out_last)
   );

endmodule

FILE: test/thai_break_position_hints_top_tb.sv
// Self-checking testbench for the Thai word-break hint block, with directed rows and random strings.
`timescale 1ns / 100ps

module thai_break_position_hints_top_tb
   import thbp_pkg::*;
();

   localparam int CYCLE_LIMIT  = 100000;
   localparam int RANDOM_ITEMS = 100;
   localparam int DRAIN_CYCLES = 10;
   localparam int NUM_ROWS     = 25;

   // One expected hint transaction.
   typedef struct packed {
      logic hint;
      logic out_last;
   } hint_result_type;

   // One directed row; typed rows are one-byte strings whose hint is known up front.
   typedef struct packed {
      logic [7:0] ch;
      logic       last;
      logic       typed;
      logic       hint;
   } stim_row_type;

   logic       clock        = 1'b0;
   logic       reset        = 1'b1;
   logic       req_valid    = 1'b0;
   logic [7:0] req_ch       = 8'h00;
   logic       req_last     = 1'b0;
   logic       rsp_ready    = 1'b0;
   logic       req_ready;
   logic       rsp_valid;
   logic       rsp_hint;
   logic       rsp_out_last;

   // Predictor state.
   logic [7:0]  byte_window [0:WIN_DEPTH-1];
   int unsigned window_count;
   logic [7:0]  prev_bytes [0:1];
   int unsigned prev_count;
   int unsigned skip_left;

   hint_result_type expected_hints [$];
   hint_result_type oldest_hint;
   int unsigned     mismatch_count = 0;
   int unsigned     cycle_count    = 0;
   int unsigned     result_count   = 0;
   int unsigned     stall_left     = 0;
   logic            rx_quiet       = 1'b0;
   logic            tx_quiet       = 1'b0;

   stim_row_type directed_rows [0:NUM_ROWS-1] = '{
      {CH_CONS_KO,    1'b1, 1'b1, 1'b1},
      {8'h00,         1'b1, 1'b1, 1'b0},
      {8'hFF,         1'b1, 1'b1, 1'b0},
      {CH_RU,         1'b1, 1'b1, 1'b1},
      {CH_LU,         1'b1, 1'b1, 1'b1},
      {CH_LEAD_E,     1'b1, 1'b1, 1'b1},
      {8'hA2,         1'b0, 1'b0, 1'b0},
      {CH_SILENCER,   1'b0, 1'b0, 1'b0},
      {8'hA3,         1'b0, 1'b0, 1'b0},
      {CH_HAN_MARK,   1'b0, 1'b0, 1'b0},
      {8'hA5,         1'b1, 1'b0, 1'b0},
      {CH_LEAD_E,     1'b0, 1'b0, 1'b0},
      {8'hA2,         1'b0, 1'b0, 1'b0},
      {8'hD4,         1'b0, 1'b0, 1'b0},
      {8'hE9,         1'b0, 1'b0, 1'b0},
      {8'hA3,         1'b1, 1'b0, 1'b0},
      {8'hB1,         1'b0, 1'b0, 1'b0},
      {CH_SHORT_MARK, 1'b0, 1'b0, 1'b0},
      {CH_CONS_O,     1'b0, 1'b0, 1'b0},
      {CH_LEAD_AE,    1'b0, 1'b0, 1'b0},
      {8'hA5,         1'b0, 1'b0, 1'b0},
      {CH_VOWEL_AA,   1'b0, 1'b0, 1'b0},
      {CH_VOWEL_A,    1'b0, 1'b0, 1'b0},
      {8'hE4,         1'b0, 1'b0, 1'b0},
      {8'hA7,         1'b1, 1'b0, 1'b0}
   };

   thai_break_position_hints_top u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_ch       (req_ch),
      .req_last     (req_last),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_hint     (rsp_hint),
      .rsp_out_last (rsp_out_last)
   );

   always #5 clock = ~clock;

   // Character classes of the TIS-620 code page.
   function automatic logic is_consonant(logic [7:0] c);
      return c >= 8'hA1 && c <= 8'hCE && c != CH_RU && c != CH_LU;
   endfunction

   function automatic logic is_tone_mark(logic [7:0] c);
      return c >= 8'hE8 && c <= 8'hEB;
   endfunction

   function automatic logic is_upper_vowel(logic [7:0] c);
      return c == CH_HAN_MARK || (c >= 8'hD4 && c <= 8'hD7);
   endfunction

   function automatic logic is_leading_vowel(logic [7:0] c);
      return c >= 8'hE0 && c <= 8'hE4;
   endfunction

   function automatic logic is_han_or_sara_uee(logic [7:0] c);
      return c == CH_HAN_MARK || c == CH_VOWEL_UEE;
   endfunction

   // Hint for the oldest pending byte and how many positions that decision spans.
   function automatic int unsigned span_of_oldest(input int unsigned n, output logic hint);
      logic [7:0] c;
      c    = byte_window[0];
      hint = 1'b0;
      if (is_consonant(c)) begin
         if (n > 1 && byte_window[1] == CH_SILENCER) return 2;
         if (n > 2 && byte_window[2] == CH_SILENCER) return 3;
         if (n > 2 && c != CH_CONS_KO && byte_window[1] == CH_SHORT_MARK &&
             (byte_window[2] == CH_CONS_O || byte_window[2] == CH_CONS_WO)) begin
            hint = 1'b1;
            return 4;
         end
         // A consonant right after mai han akat or sara uee, maybe with a tone between,
         // continues the syllable.
         if ((prev_count >= 1 && is_han_or_sara_uee(prev_bytes[0])) ||
             (prev_count >= 2 && is_tone_mark(prev_bytes[0]) &&
              is_han_or_sara_uee(prev_bytes[1])))
            return 1;
         hint = 1'b1;
         return 1;
      end
      if (c == CH_LEAD_E || c == CH_LEAD_AE) begin
         hint = 1'b1;
         if (n <= 2) return 2;
         if (byte_window[2] == CH_SHORT_MARK) return 4;
         if (is_upper_vowel(byte_window[2]))
            return (n > 3 && is_tone_mark(byte_window[3])) ? 5 : 4;
         if (n > 4 &&
             ((byte_window[3] == CH_VOWEL_AA && byte_window[4] == CH_VOWEL_A) ||
              (byte_window[2] != CH_CONS_KO && byte_window[3] == CH_SHORT_MARK &&
               byte_window[4] != CH_CONS_O && byte_window[4] != CH_CONS_WO)))
            return 5;
         return 2;
      end
      if (is_leading_vowel(c)) begin
         hint = 1'b1;
         return 2;
      end
      if (c == CH_RU || c == CH_LU) hint = 1'b1;
      return 1;
   endfunction

   // Start a new string: empty window, no history, no pending skip.
   task automatic clear_string_state();
      for (int i = 0; i < WIN_DEPTH; i++) byte_window[i] = 8'h00;
      prev_bytes[0] = 8'h00;
      prev_bytes[1] = 8'h00;
      window_count  = 0;
      prev_count    = 0;
      skip_left     = 0;
   endtask

   // Update the predictor with one accepted byte and queue the hints it releases.
   task automatic predict_hints(input logic [7:0] ch, input logic last);
      logic        hint;
      int unsigned span;
      if (window_count < WIN_DEPTH) begin
         byte_window[window_count] = ch;
         window_count++;
      end
      while (window_count >= WIN_DEPTH || (last && window_count > 0)) begin
         hint = 1'b0;
         if (skip_left > 0) begin
            skip_left--;
         end else begin
            span      = span_of_oldest(window_count, hint);
            skip_left = span - 1;
         end
         expected_hints.push_back('{hint: hint, out_last: last && window_count == 1});
         prev_bytes[1] = prev_bytes[0];
         prev_bytes[0] = byte_window[0];
         if (prev_count < 2) prev_count++;
         for (int i = 0; i < WIN_DEPTH - 1; i++) byte_window[i] = byte_window[i+1];
         byte_window[WIN_DEPTH-1] = 8'h00;
         window_count--;
      end
      // A skip that reaches past the final byte is simply dropped here.
      if (last) clear_string_state();
   endtask

   task automatic report_mismatch(input string what);
      $display("mismatch at cycle %0d, result %0d: %s", cycle_count, result_count, what);
      mismatch_count++;
   endtask

   // Present one byte and hold it until the transaction completes.
   task automatic send_byte(input logic [7:0] ch, input logic last);
      @(negedge clock);
      req_valid <= 1'b1;
      req_ch    <= ch;
      req_last  <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_hints(ch, last);
   endtask

   // Sender gap: mostly none or short, now and then long.
   task automatic idle_sender();
      int unsigned roll;
      int unsigned gap;
      roll = $urandom_range(0, 99);
      gap  = 0;
      if (!tx_quiet) begin
         if (roll >= 90) gap = $urandom_range(8, 25);
         else if (roll >= 60) gap = $urandom_range(1, 3);
      end
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
   endtask

   task automatic wait_for_drain();
      while (expected_hints.size() != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] pick_consonant();
      return ($urandom_range(0, 5) == 0) ? CH_CONS_KO : 8'($urandom_range(8'hA1, 8'hCE));
   endfunction

   function automatic logic [7:0] pick_sara_e_ae();
      return $urandom_range(0, 1) ? CH_LEAD_AE : CH_LEAD_E;
   endfunction

   // One byte drawn mostly from the characters that the rules look at.
   function automatic logic [7:0] pick_thai_byte();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 30) return 8'($urandom_range(8'hA1, 8'hCE));
      if (roll < 38) return CH_CONS_KO;
      if (roll < 46) return CH_SILENCER;
      if (roll < 54) return CH_SHORT_MARK;
      if (roll < 60) return $urandom_range(0, 1) ? CH_CONS_O : CH_CONS_WO;
      if (roll < 68) return $urandom_range(0, 4) == 0 ? CH_HAN_MARK
                                                       : 8'($urandom_range(8'hD4, 8'hD7));
      if (roll < 76) return 8'($urandom_range(8'hE8, 8'hEB));
      if (roll < 86) return 8'($urandom_range(8'hE0, 8'hE4));
      if (roll < 90) return CH_VOWEL_AA;
      if (roll < 93) return CH_VOWEL_A;
      return 8'($urandom_range(0, 255));
   endfunction

   // Build a string from syllable-like fragments with random content, or plain noise,
   // and send it; returns the number of bytes sent.
   task automatic send_random_string(output int unsigned sent);
      logic [7:0]  word_bytes [$];
      int unsigned pieces;
      pieces = $urandom_range(1, 4);
      word_bytes.delete();
      tx_quiet = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 8)) word_bytes.push_back(8'($urandom_range(0, 255)));
      end else begin
         repeat (pieces) begin
            case ($urandom_range(0, 9))
               0: word_bytes.push_back(pick_thai_byte());
               1: begin
                  word_bytes.push_back(pick_sara_e_ae());
                  word_bytes.push_back(pick_consonant());
                  word_bytes.push_back(CH_VOWEL_AA);
                  word_bytes.push_back(CH_VOWEL_A);
               end
               2: begin
                  word_bytes.push_back(pick_sara_e_ae());
                  word_bytes.push_back(pick_consonant());
                  word_bytes.push_back(CH_SHORT_MARK);
                  word_bytes.push_back(pick_thai_byte());
               end
               3: begin
                  word_bytes.push_back(pick_consonant());
                  word_bytes.push_back(CH_SHORT_MARK);
                  word_bytes.push_back($urandom_range(0, 1) ? CH_CONS_O : CH_CONS_WO);
               end
               4: begin
                  word_bytes.push_back(pick_consonant());
                  word_bytes.push_back(CH_SILENCER);
               end
               5: begin
                  word_bytes.push_back(pick_consonant());
                  word_bytes.push_back(pick_thai_byte());
                  word_bytes.push_back(CH_SILENCER);
               end
               6: begin
                  word_bytes.push_back(pick_consonant());
                  word_bytes.push_back($urandom_range(0, 1) ? CH_HAN_MARK
                                                             : CH_VOWEL_UEE);
                  if ($urandom_range(0, 1)) word_bytes.push_back(8'($urandom_range(8'hE8, 8'hEB)));
                  word_bytes.push_back(pick_consonant());
               end
               7: begin
                  word_bytes.push_back(pick_sara_e_ae());
                  word_bytes.push_back(pick_consonant());
                  word_bytes.push_back($urandom_range(0, 1) ? CH_HAN_MARK
                                                             : 8'($urandom_range(8'hD4, 8'hD7)));
                  if ($urandom_range(0, 1)) word_bytes.push_back(8'($urandom_range(8'hE8, 8'hEB)));
                  word_bytes.push_back(pick_consonant());
               end
               8: begin
                  word_bytes.push_back(pick_sara_e_ae());
                  word_bytes.push_back(pick_consonant());
                  word_bytes.push_back(CH_SHORT_MARK);
               end
               default: begin
                  repeat (3) word_bytes.push_back(8'($urandom_range(0, 255)));
               end
            endcase
         end
      end
      for (int i = 0; i < word_bytes.size(); i++) begin
         send_byte(word_bytes[i], i == word_bytes.size() - 1);
         idle_sender();
      end
      sent = word_bytes.size();
   endtask

   // Receiver stalls: quiet stretches, short stalls and the odd long one.
   always @(negedge clock) begin
      if (cycle_count % 200 == 0) rx_quiet = ($urandom_range(0, 2) == 0);
      if (stall_left == 0 && !rx_quiet) begin
         if ($urandom_range(0, 99) < 20) stall_left = $urandom_range(1, 3);
         else if ($urandom_range(0, 99) < 4) stall_left = $urandom_range(8, 30);
      end
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Compare each completed result transaction with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_hints.size() == 0) begin
            report_mismatch("result with no expectation pending");
         end else begin
            oldest_hint = expected_hints.pop_front();
            if (rsp_hint !== oldest_hint.hint)
               report_mismatch($sformatf("hint %b, expected %b", rsp_hint, oldest_hint.hint));
            if (rsp_out_last !== oldest_hint.out_last)
               report_mismatch($sformatf("out_last %b, expected %b", rsp_out_last,
                                         oldest_hint.out_last));
         end
         result_count++;
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      int unsigned     random_sent;
      int unsigned     sent;
      hint_result_type typed_hint;
      random_sent = 0;
      clear_string_state();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed rows; typed rows override the prediction with their known hint.
      for (int r = 0; r < NUM_ROWS; r++) begin
         send_byte(directed_rows[r].ch, directed_rows[r].last);
         if (directed_rows[r].typed) begin
            typed_hint = expected_hints.pop_back();
            typed_hint.hint = directed_rows[r].hint;
            expected_hints.push_back(typed_hint);
         end
         idle_sender();
      end

      // Hold the sender off until every pending hint has come back.
      @(negedge clock);
      req_valid <= 1'b0;
      wait_for_drain();

      while (random_sent < RANDOM_ITEMS) begin
         send_random_string(sent);
         random_sent += sent;
      end

      @(negedge clock);
      req_valid <= 1'b0;
      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_hints.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
